@@ hdl/wmm_pkg.sv @@
// Shared types and constants of the min/max waveform column block.
package wmm_pkg;

  // Fixed field widths of the register file and the column counters.
  localparam int unsigned COL_W      = 16;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned RANGE_W    = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned DIV_STEPS  = RANGE_W;
  localparam int unsigned STEP_W     = $clog2(DIV_STEPS);

  typedef enum logic [CFG_IDX_W-1:0] {
    CfgChannelCount     = 2'd0,
    CfgRangeFrames      = 2'd1,
    CfgRequestedColumns = 2'd2
  } cfg_reg_e;

  // Column split and channel setup, valid while ready is high.
  typedef struct packed {
    logic               ready;
    logic               range_zero;
    logic [CNT_W-1:0]   chans_m1;
    logic [COL_W-1:0]   cols_m1;
    logic [RANGE_W-1:0] base_span;
    logic [COL_W-1:0]   rem_cols;
  } setup_t;

  // One accepted sample's place in the view.
  typedef struct packed {
    logic             valid;
    logic             seed;
    logic             close;
    logic             view_end;
    logic [COL_W-1:0] col;
    logic [CNT_W-1:0] chan;
  } acc_t;

  // Emission state seen by the input side for the bank interlock.
  typedef struct packed {
    logic job_active;
    logic job_bank;
    logic pending;
  } busy_t;

endpackage

@@ hdl/wmm_setup.sv @@
// Configuration registers and the serial divider that splits the range into columns.
module wmm_setup #(
  parameter int unsigned MAX_CHANNELS = 8,
  parameter int unsigned MAX_COLUMNS  = 65535
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [wmm_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [wmm_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output wmm_pkg::setup_t                     setup_o
);

  localparam logic [31:0] MaxCols  = 32'(MAX_COLUMNS);
  localparam logic [31:0] MaxChans = 32'(MAX_CHANNELS);

  logic [wmm_pkg::CNT_W-1:0]   chan_cnt_q;
  logic [wmm_pkg::RANGE_W-1:0] range_q;
  logic [wmm_pkg::COL_W-1:0]   req_q;
  logic                        load_q;
  logic                        busy_q;
  logic [wmm_pkg::STEP_W-1:0]  step_q;
  logic [wmm_pkg::RANGE_W-1:0] quo_q;
  logic [wmm_pkg::COL_W-1:0]   rem_q;
  logic [wmm_pkg::COL_W-1:0]   cols_q;
  logic [wmm_pkg::CNT_W-1:0]   chans_m1_q;
  logic                        range_zero_q;

  logic [wmm_pkg::COL_W-1:0]   req_c;
  logic [wmm_pkg::COL_W-1:0]   cols_c;
  logic [wmm_pkg::CNT_W-1:0]   chans_c;
  logic [wmm_pkg::COL_W:0]     trial;
  logic [wmm_pkg::COL_W:0]     diff;
  logic                        fits;

  always_comb begin
    req_c = (req_q == '0) ? wmm_pkg::COL_W'(1) : req_q;
    if ({16'd0, req_c} > MaxCols) begin
      req_c = MaxCols[wmm_pkg::COL_W-1:0];
    end
    // Never more columns than frames; the range is then below 2^16.
    cols_c = ({16'd0, req_c} > range_q) ? range_q[wmm_pkg::COL_W-1:0] : req_c;
    chans_c = (chan_cnt_q == '0) ? wmm_pkg::CNT_W'(1) : chan_cnt_q;
    if ({28'd0, chans_c} > MaxChans) begin
      chans_c = MaxChans[wmm_pkg::CNT_W-1:0];
    end
  end

  // One quotient bit per cycle, restoring form.
  assign trial = {rem_q, quo_q[wmm_pkg::RANGE_W-1]};
  assign fits  = trial >= {1'b0, cols_q};
  assign diff  = trial - {1'b0, cols_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_cnt_q   <= wmm_pkg::CNT_W'(1);
      range_q      <= wmm_pkg::RANGE_W'(1);
      req_q        <= wmm_pkg::COL_W'(1);
      load_q       <= 1'b1;
      busy_q       <= 1'b0;
      step_q       <= '0;
      quo_q        <= '0;
      rem_q        <= '0;
      cols_q       <= wmm_pkg::COL_W'(1);
      chans_m1_q   <= '0;
      range_zero_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (wmm_pkg::cfg_reg_e'(cfg_index_i))
        wmm_pkg::CfgChannelCount:     chan_cnt_q <= cfg_data_i[wmm_pkg::CNT_W-1:0];
        wmm_pkg::CfgRangeFrames:      range_q    <= cfg_data_i[wmm_pkg::RANGE_W-1:0];
        wmm_pkg::CfgRequestedColumns: req_q      <= cfg_data_i[wmm_pkg::COL_W-1:0];
        default: begin
        end
      endcase
      load_q <= 1'b1;
      busy_q <= 1'b0;
    end else if (load_q) begin
      load_q       <= 1'b0;
      cols_q       <= cols_c;
      chans_m1_q   <= chans_c - wmm_pkg::CNT_W'(1);
      range_zero_q <= (range_q == '0);
      busy_q       <= (range_q != '0);
      step_q       <= '0;
      quo_q        <= range_q;
      rem_q        <= '0;
    end else if (busy_q) begin
      quo_q  <= {quo_q[wmm_pkg::RANGE_W-2:0], fits};
      rem_q  <= fits ? diff[wmm_pkg::COL_W-1:0] : trial[wmm_pkg::COL_W-1:0];
      step_q <= step_q + wmm_pkg::STEP_W'(1);
      if (step_q == wmm_pkg::STEP_W'(wmm_pkg::DIV_STEPS - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_comb begin
    setup_o.ready      = !load_q && !busy_q;
    setup_o.range_zero = range_zero_q;
    setup_o.chans_m1   = chans_m1_q;
    setup_o.cols_m1    = cols_q - wmm_pkg::COL_W'(1);
    setup_o.base_span  = quo_q;
    setup_o.rem_cols   = rem_q;
  end

endmodule

@@ hdl/wmm_seq.sv @@
// Input sequencer: channel, frame and column counters and the input handshake.
module wmm_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  wmm_pkg::setup_t setup_i,
  input  wmm_pkg::busy_t  busy_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output wmm_pkg::acc_t   acc_o
);

  logic [wmm_pkg::CNT_W-1:0]   ch_q;
  logic [wmm_pkg::CNT_W-1:0]   ch_d;
  logic [wmm_pkg::RANGE_W-1:0] frame_q;
  logic [wmm_pkg::RANGE_W-1:0] frame_d;
  logic [wmm_pkg::COL_W-1:0]   col_q;
  logic [wmm_pkg::COL_W-1:0]   col_d;

  logic                        accept;
  logic                        last_ch;
  logic                        close;
  logic                        view_end;
  logic [wmm_pkg::RANGE_W-1:0] span;
  logic [wmm_pkg::RANGE_W-1:0] frame_nx;

  // A column may not start refilling its bank while that bank is still being read out.
  assign in_ready_o = setup_i.ready && !busy_i.pending &&
                      !(busy_i.job_active && (busy_i.job_bank == col_q[0]));
  assign accept     = in_valid_i && in_ready_o;

  assign last_ch  = (ch_q == setup_i.chans_m1);
  assign span     = setup_i.base_span +
                    wmm_pkg::RANGE_W'(col_q < setup_i.rem_cols);
  assign frame_nx = frame_q + wmm_pkg::RANGE_W'(1);
  assign close    = last_ch && (frame_nx == span);
  assign view_end = (col_q == setup_i.cols_m1);

  always_comb begin
    ch_d    = ch_q;
    frame_d = frame_q;
    col_d   = col_q;
    if (accept && !setup_i.range_zero) begin
      if (!last_ch) begin
        ch_d = ch_q + wmm_pkg::CNT_W'(1);
      end else begin
        ch_d = '0;
        if (close) begin
          frame_d = '0;
          col_d   = view_end ? '0 : col_q + wmm_pkg::COL_W'(1);
        end else begin
          frame_d = frame_nx;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q    <= '0;
      frame_q <= '0;
      col_q   <= '0;
    end else if (cfg_we_i) begin
      ch_q    <= '0;
      frame_q <= '0;
      col_q   <= '0;
    end else begin
      ch_q    <= ch_d;
      frame_q <= frame_d;
      col_q   <= col_d;
    end
  end

  always_comb begin
    acc_o.valid    = accept && !setup_i.range_zero;
    acc_o.seed     = (frame_q == '0);
    acc_o.close    = close;
    acc_o.view_end = view_end;
    acc_o.col      = col_q;
    acc_o.chan     = ch_q;
  end

endmodule

@@ hdl/wmm_peak_mem.sv @@
// Min/max store with read-modify-write update and the column readout to the output register.
module wmm_peak_mem #(
  parameter int unsigned MAX_CHANNELS = 8,
  parameter int unsigned SAMPLE_BITS  = 24,
  localparam int unsigned ChW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wmm_pkg::setup_t               setup_i,
  input  wmm_pkg::acc_t                 acc_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output wmm_pkg::busy_t                busy_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [wmm_pkg::COL_W-1:0]     out_col_o,
  output logic [ChW-1:0]                out_ch_o,
  output logic signed [SAMPLE_BITS-1:0] out_min_o,
  output logic signed [SAMPLE_BITS-1:0] out_max_o,
  output logic                          out_last_col_o,
  output logic                          out_last_view_o
);

  localparam int unsigned AddrW = ChW + 1;
  localparam int unsigned Depth = 1 << AddrW;
  localparam int unsigned WordW = 2 * SAMPLE_BITS;

  // Two banks by column parity: one fills while the other is read out.
  logic [WordW-1:0] mem [Depth];

  logic [AddrW-1:0]              addr_a;
  logic [WordW-1:0]              rd_a_q;
  logic [WordW-1:0]              rd_b_q;

  logic                          s1_valid_q;
  logic [AddrW-1:0]              s1_addr_q;
  logic signed [SAMPLE_BITS-1:0] s1_sample_q;
  logic                          s1_seed_q;
  logic                          s1_close_q;
  logic [wmm_pkg::COL_W-1:0]     s1_col_q;
  logic                          s1_view_q;

  logic                          fwd_valid_q;
  logic [AddrW-1:0]              fwd_addr_q;
  logic [WordW-1:0]              fwd_data_q;

  logic [WordW-1:0]              old_word;
  logic signed [SAMPLE_BITS-1:0] old_min;
  logic signed [SAMPLE_BITS-1:0] old_max;
  logic signed [SAMPLE_BITS-1:0] new_min;
  logic signed [SAMPLE_BITS-1:0] new_max;
  logic [WordW-1:0]              new_word;

  logic                          job_active_q;
  logic [wmm_pkg::COL_W-1:0]     job_col_q;
  logic                          job_view_q;
  logic [ChW-1:0]                ech_q;
  logic                          pend_valid_q;
  logic [wmm_pkg::COL_W-1:0]     pend_col_q;
  logic                          pend_view_q;

  logic                          e1_valid_q;
  logic [wmm_pkg::COL_W-1:0]     e1_col_q;
  logic [ChW-1:0]                e1_ch_q;
  logic                          e1_lcol_q;
  logic                          e1_lview_q;

  logic                          m_valid_q;
  logic [wmm_pkg::COL_W-1:0]     m_col_q;
  logic [ChW-1:0]                m_ch_q;
  logic signed [SAMPLE_BITS-1:0] m_min_q;
  logic signed [SAMPLE_BITS-1:0] m_max_q;
  logic                          m_lcol_q;
  logic                          m_lview_q;

  logic [ChW-1:0]                chans_m1;
  logic                          job_last;
  logic                          e1_adv;
  logic                          issue;
  logic                          job_free;

  assign chans_m1 = ChW'(setup_i.chans_m1);
  assign addr_a   = {acc_i.col[0], ChW'(acc_i.chan)};

  // The previous cycle's write is not yet visible in the read data.
  assign old_word = (fwd_valid_q && (fwd_addr_q == s1_addr_q)) ? fwd_data_q : rd_a_q;
  assign old_min  = old_word[SAMPLE_BITS-1:0];
  assign old_max  = old_word[WordW-1:SAMPLE_BITS];

  always_comb begin
    if (s1_seed_q) begin
      new_min = s1_sample_q;
      new_max = s1_sample_q;
    end else begin
      new_min = (s1_sample_q < old_min) ? s1_sample_q : old_min;
      new_max = (s1_sample_q > old_max) ? s1_sample_q : old_max;
    end
  end
  assign new_word = {new_max, new_min};

  assign job_last = (ech_q == chans_m1);
  assign e1_adv   = e1_valid_q && (!m_valid_q || out_ready_i);
  assign issue    = job_active_q && (!e1_valid_q || e1_adv);
  assign job_free = !job_active_q || (issue && job_last);

  always_ff @(posedge clk_i) begin
    if (acc_i.valid) begin
      rd_a_q <= mem[addr_a];
    end
    if (issue) begin
      rd_b_q <= mem[{job_col_q[0], ech_q}];
    end
    if (s1_valid_q) begin
      mem[s1_addr_q] <= new_word;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_addr_q   <= addr_a;
    s1_sample_q <= sample_i;
    s1_seed_q   <= acc_i.seed;
    s1_close_q  <= acc_i.close;
    s1_col_q    <= acc_i.col;
    s1_view_q   <= acc_i.view_end;
    fwd_addr_q  <= s1_addr_q;
    fwd_data_q  <= new_word;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= acc_i.valid;
      fwd_valid_q <= s1_valid_q;
    end
  end

  // Readout jobs: one active, one waiting behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_active_q <= 1'b0;
      job_col_q    <= '0;
      job_view_q   <= 1'b0;
      ech_q        <= '0;
      pend_valid_q <= 1'b0;
      pend_col_q   <= '0;
      pend_view_q  <= 1'b0;
    end else begin
      if (issue) begin
        ech_q <= job_last ? '0 : ech_q + ChW'(1);
      end
      if (job_free) begin
        if (pend_valid_q) begin
          job_active_q <= 1'b1;
          job_col_q    <= pend_col_q;
          job_view_q   <= pend_view_q;
          pend_valid_q <= s1_valid_q && s1_close_q;
          pend_col_q   <= s1_col_q;
          pend_view_q  <= s1_view_q;
        end else if (s1_valid_q && s1_close_q) begin
          job_active_q <= 1'b1;
          job_col_q    <= s1_col_q;
          job_view_q   <= s1_view_q;
        end else begin
          job_active_q <= 1'b0;
        end
      end else if (s1_valid_q && s1_close_q) begin
        pend_valid_q <= 1'b1;
        pend_col_q   <= s1_col_q;
        pend_view_q  <= s1_view_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      e1_col_q   <= job_col_q;
      e1_ch_q    <= ech_q;
      e1_lcol_q  <= job_last;
      e1_lview_q <= job_last && job_view_q;
    end
    if (e1_adv) begin
      m_col_q   <= e1_col_q;
      m_ch_q    <= e1_ch_q;
      m_min_q   <= rd_b_q[SAMPLE_BITS-1:0];
      m_max_q   <= rd_b_q[WordW-1:SAMPLE_BITS];
      m_lcol_q  <= e1_lcol_q;
      m_lview_q <= e1_lview_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      if (issue) begin
        e1_valid_q <= 1'b1;
      end else if (e1_adv) begin
        e1_valid_q <= 1'b0;
      end
      if (e1_adv) begin
        m_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    busy_o.job_active = job_active_q;
    busy_o.job_bank   = job_col_q[0];
    busy_o.pending    = pend_valid_q;
  end

  assign out_valid_o     = m_valid_q;
  assign out_col_o       = m_col_q;
  assign out_ch_o        = m_ch_q;
  assign out_min_o       = m_min_q;
  assign out_max_o       = m_max_q;
  assign out_last_col_o  = m_lcol_q;
  assign out_last_view_o = m_lview_q;

endmodule

@@ hdl/waveform_min_max_columns.sv @@
// Min/max waveform column reduction: channel-interleaved samples in, per-column peaks out.
//
// Samples enter on the s_axis word stream, channels interleaved frame by frame, from the
// first frame of the range. The range is split into min(requested, frames) columns; the
// first (frames mod columns) columns are one frame longer. When a column's last sample is
// taken, one word per channel leaves on m_axis in channel order: tuser marks the last
// channel of a column, tlast the very last word of the range. After the range's last
// sample is taken, the next sample starts a new pass.
// After a column's closing sample is accepted, its words pass the write stage, the readout
// job register, the read stage and the output register. Output moves one word per cycle
// while m_axis_tready is high. Input takes one word per cycle too, except that a column
// may not start in a bank whose readout is still running.
// Reset and every register write restart the pass and run a one-bit-per-cycle divider for
// the column split; s_axis_tready stays low while it runs.
// When m_axis stalls, finished words wait in the output register and one staging word;
// the input keeps flowing until a column needs the bank being drained, or until a second
// finished column is queued behind the readout. Registers are written by the user through
// cfg_we_i, cfg_index_i and cfg_data_i only while idle; the block does not enforce it.
module waveform_min_max_columns #(
  parameter int unsigned MAX_CHANNELS = 8,
  parameter int unsigned MAX_COLUMNS  = 65535,
  parameter int unsigned SAMPLE_BITS  = 24,
  localparam int unsigned ChW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
  localparam int unsigned InTdW = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int unsigned OutW  = wmm_pkg::COL_W + ChW + 2 * SAMPLE_BITS,
  localparam int unsigned OutTdW = ((OutW + 7) / 8) * 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [wmm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [wmm_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [InTdW-1:0]                 s_axis_tdata,  // sample
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [OutTdW-1:0]                m_axis_tdata,  // column_index, channel_index,
                                                          // peak_minimum, peak_maximum
  output logic                             m_axis_tuser,  // last_of_column
  output logic                             m_axis_tlast   // last_of_view
);

  wmm_pkg::setup_t               setup;
  wmm_pkg::busy_t                busy;
  wmm_pkg::acc_t                 acc;
  logic [wmm_pkg::COL_W-1:0]     out_col;
  logic [ChW-1:0]                out_ch;
  logic signed [SAMPLE_BITS-1:0] out_min;
  logic signed [SAMPLE_BITS-1:0] out_max;

  wmm_setup #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_COLUMNS  (MAX_COLUMNS)
  ) u_setup (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .setup_o     (setup)
  );

  wmm_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .setup_i    (setup),
    .busy_i     (busy),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .acc_o      (acc)
  );

  wmm_peak_mem #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_peak_mem (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .setup_i         (setup),
    .acc_i           (acc),
    .sample_i        (s_axis_tdata[SAMPLE_BITS-1:0]),
    .busy_o          (busy),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_col_o       (out_col),
    .out_ch_o        (out_ch),
    .out_min_o       (out_min),
    .out_max_o       (out_max),
    .out_last_col_o  (m_axis_tuser),
    .out_last_view_o (m_axis_tlast)
  );

  assign m_axis_tdata = OutTdW'({out_max, out_min, out_ch, out_col});

endmodule
